// ===== hw/rtl/dai_pkg.sv =====
// Depth attenuation interpolator: shared types, constants and sizes.
// No dependencies; every other file of the block imports this package.
package dai_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int PROD_W      = 32 + IDX_W;
  // Dividend width covers depth*(n-1) and the 48-bit fraction dividend.
  localparam int DIVD_W      = (PROD_W > 48) ? PROD_W : 48;
  localparam int DCNT_W      = $clog2(DIVD_W + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] THICKNESS_RST = 32'h0001_0000;
  localparam logic [16:0] ONE_Q16       = 17'h1_0000;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_MAX_ZERO = 2'd2;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  // Where a query's y falls against the layer
  typedef enum logic [1:0] {
    REG_TZERO  = 2'd0,
    REG_TOP    = 2'd1,
    REG_BOTTOM = 2'd2,
    REG_INSIDE = 2'd3
  } region_e;

  typedef struct packed {
    cmd_e        cmd;
    region_e     region;
    logic [15:0] entry_value;
    logic [31:0] depth;
    logic        interp;
  } q_item_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [31:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quot;
    logic [31:0]       rem;
  } div_rsp_t;

endpackage

// ===== hw/rtl/dai_front.sv =====
// Front end: takes input transactions, decodes the command and places a
// query's y against the layer. Depends on dai_pkg; feeds dai_fifo.
module dai_front import dai_pkg::*; (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         command_i,
  input  logic [15:0]        entry_value_i,
  input  logic signed [31:0] y_coord_i,
  input  logic               interpolate_i,
  input  logic [31:0]        thickness_i,
  input  logic               full_i,
  output logic               push_o,
  output q_item_t            item_o
);

  logic y_top;
  logic y_bottom;

  // y >= T only possible when y is non-negative
  assign y_top    = !y_coord_i[31] && (y_coord_i[31:0] >= thickness_i);
  assign y_bottom = y_coord_i[31] || (y_coord_i == 32'sd0);

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    item_o.cmd         = cmd_e'(command_i);
    item_o.entry_value = entry_value_i;
    item_o.interp      = interpolate_i;
    item_o.depth       = thickness_i - y_coord_i[31:0];
    if (thickness_i == 32'd0) begin
      item_o.region = REG_TZERO;
    end else if (y_top) begin
      item_o.region = REG_TOP;
    end else if (y_bottom) begin
      item_o.region = REG_BOTTOM;
    end else begin
      item_o.region = REG_INSIDE;
    end
  end

endmodule

// ===== hw/rtl/dai_fifo.sv =====
// Short queue between front end and back end of the interpolator.
// Depends on dai_pkg for the item type and depth.
module dai_fifo import dai_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_item_t item_i,
  output logic    full_o,
  output logic    valid_o,
  input  logic    pop_i,
  output q_item_t item_o
);

  q_item_t             slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;
  logic                do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = slots_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/dai_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on dai_pkg for the request and response structs.
module dai_div import dai_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DIVD_W-1:0] quo_q, quo_d;
  logic [31:0]       rem_q, rem_d;
  logic [31:0]       divisor_q;
  logic [DCNT_W-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [32:0]       rem_sh;
  logic              ge;

  assign rem_sh = {rem_q, quo_q[DIVD_W-1]};
  assign ge     = (rem_sh >= {1'b0, divisor_q});
  assign rem_d  = ge ? 32'(rem_sh - {1'b0, divisor_q}) : rem_sh[31:0];
  assign quo_d  = {quo_q[DIVD_W-2:0], ge};

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q     <= req_i.dividend;
      rem_q     <= '0;
      divisor_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DCNT_W'(DIVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== hw/rtl/dai_back.sv =====
// Back end: curve table, entry count and maximum, query sequencer and the
// output register. Depends on dai_pkg; drives the shared dai_div.
module dai_back import dai_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] thickness_i,
  input  logic        q_valid_i,
  input  q_item_t     q_item_i,
  output logic        q_pop_o,
  output div_req_t    div_req_o,
  input  div_rsp_t    div_rsp_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [16:0] attenuation_o,
  output logic [1:0]  status_o
);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0_0000_0000_0001,
    S_RD_NORM  = 13'b0_0000_0000_0010,
    S_NORM_GO  = 13'b0_0000_0000_0100,
    S_MUL      = 13'b0_0000_0000_1000,
    S_IDX_GO   = 13'b0_0000_0001_0000,
    S_WAIT_IDX = 13'b0_0000_0010_0000,
    S_WAIT_TQ  = 13'b0_0000_0100_0000,
    S_RD_E1    = 13'b0_0000_1000_0000,
    S_BLEND    = 13'b0_0001_0000_0000,
    S_SUM      = 13'b0_0010_0000_0000,
    S_WAIT_RES = 13'b0_0100_0000_0000,
    S_OUT      = 13'b0_1000_0000_0000,
    S_SPARE    = 13'b1_0000_0000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [15:0]       max_q, max_d;

  logic [15:0]       table_mem [TABLE_DEPTH];
  logic              wr_en;
  logic [IDX_W-1:0]  rd_addr_q, rd_addr_d;
  logic [15:0]       rd_data_q;

  logic [31:0]       depth_q;
  logic              interp_q;
  logic [PROD_W-1:0] prod_q;
  logic [IDX_W-1:0]  idx_q, idx_c;
  logic [15:0]       tq_q;
  logic [15:0]       e0_q;
  logic [32:0]       p0_q, p1_q;
  logic [16:0]       res_att_q, res_att_d;
  logic [1:0]        res_status_q, res_status_d;
  logic              out_valid_q;
  logic [16:0]       att_out_q;
  logic [1:0]        status_out_q;

  logic              out_free;
  logic [IDX_W-1:0]  nm1;
  logic [CNT_W-1:0]  nm2;

  assign out_free = !out_valid_q || !out_stall_i;
  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i;
  assign nm1      = IDX_W'(count_q - 1'b1);
  assign nm2      = count_q - CNT_W'(2);
  // Clamp the segment index to the last pair of entries
  assign idx_c    = (div_rsp_i.quot > DIVD_W'(nm2)) ? IDX_W'(nm2)
                                                   : div_rsp_i.quot[IDX_W-1:0];
  assign wr_en    = q_pop_o && (q_item_i.cmd == CMD_APPEND)
                    && (count_q != CNT_W'(TABLE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[count_q[IDX_W-1:0]] <= q_item_i.entry_value;
    end
    rd_data_q <= table_mem[rd_addr_q];
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    max_d        = max_q;
    rd_addr_d    = rd_addr_q;
    res_att_d    = res_att_q;
    res_status_d = res_status_q;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = DIVD_W'({rd_data_q, 16'h0000});
    div_req_o.divisor  = {16'h0000, max_q};

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          res_att_d    = '0;
          res_status_d = STATUS_OK;
          state_d      = S_OUT;
          case (q_item_i.cmd)
            CMD_CLEAR: begin
              count_d = '0;
              max_d   = '0;
            end
            CMD_APPEND: begin
              if (count_q == CNT_W'(TABLE_DEPTH)) begin
                res_status_d = STATUS_FULL;
              end else begin
                count_d = count_q + 1'b1;
                if (q_item_i.entry_value > max_q) begin
                  max_d = q_item_i.entry_value;
                end
              end
            end
            CMD_QUERY: begin
              if (count_q == '0 || q_item_i.region == REG_TZERO) begin
                res_att_d = ONE_Q16;
              end else if (max_q == '0) begin
                res_status_d = STATUS_MAX_ZERO;
              end else if (q_item_i.region == REG_TOP) begin
                rd_addr_d = '0;
                state_d   = S_RD_NORM;
              end else if (q_item_i.region == REG_BOTTOM || count_q == CNT_W'(1)) begin
                rd_addr_d = nm1;
                state_d   = S_RD_NORM;
              end else begin
                state_d = S_MUL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD_NORM: state_d = S_NORM_GO;
      S_NORM_GO: begin
        div_req_o.start = 1'b1;
        state_d         = S_WAIT_RES;
      end
      S_MUL:     state_d = S_IDX_GO;
      S_IDX_GO: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = DIVD_W'(prod_q);
        div_req_o.divisor  = thickness_i;
        state_d            = S_WAIT_IDX;
      end
      S_WAIT_IDX: begin
        if (div_rsp_i.done) begin
          if (interp_q) begin
            // Chain the fraction division straight off the remainder
            div_req_o.start    = 1'b1;
            div_req_o.dividend = DIVD_W'({div_rsp_i.rem, 16'h0000});
            div_req_o.divisor  = thickness_i;
            rd_addr_d          = idx_c;
            state_d            = S_WAIT_TQ;
          end else begin
            rd_addr_d = idx_c + 1'b1;
            state_d   = S_RD_NORM;
          end
        end
      end
      S_WAIT_TQ: begin
        if (div_rsp_i.done) begin
          rd_addr_d = idx_q + 1'b1;
          state_d   = S_RD_E1;
        end
      end
      S_RD_E1:   state_d = S_BLEND;
      S_BLEND:   state_d = S_SUM;
      S_SUM: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = DIVD_W'(p0_q) + DIVD_W'(p1_q);
        state_d            = S_WAIT_RES;
      end
      S_WAIT_RES: begin
        if (div_rsp_i.done) begin
          res_att_d = div_rsp_i.quot[16:0];
          state_d   = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rd_addr_q    <= rd_addr_d;
    res_att_q    <= res_att_d;
    res_status_q <= res_status_d;
    if (q_pop_o) begin
      depth_q  <= q_item_i.depth;
      interp_q <= q_item_i.interp;
    end
    if (state_q == S_MUL) begin
      prod_q <= PROD_W'(depth_q) * PROD_W'(nm1);
    end
    if (state_q == S_WAIT_IDX && div_rsp_i.done) begin
      idx_q <= idx_c;
    end
    if (state_q == S_WAIT_TQ && div_rsp_i.done) begin
      tq_q <= div_rsp_i.quot[15:0];
      e0_q <= rd_data_q;
    end
    if (state_q == S_BLEND) begin
      p0_q <= 33'(e0_q) * 33'(ONE_Q16 - {1'b0, tq_q});
      p1_q <= 33'(rd_data_q) * 33'(tq_q);
    end
    if (state_q == S_OUT && out_free) begin
      att_out_q    <= res_att_q;
      status_out_q <= res_status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      max_q   <= max_d;
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign attenuation_o = att_out_q;
  assign status_o      = status_out_q;

endmodule

// ===== hw/rtl/depth_attenuation_interpolator.sv =====
// Depth attenuation interpolator, top level: thickness register, front end,
// queue, back end and shared divider. Depends on dai_pkg and all dai_* modules.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o) carries one command per
//    transaction: clear, append a curve sample, query at y, or no-op.
//  - Output channel (out_valid_o / out_stall_i) returns exactly one result
//    per input transaction, in order: attenuation in Q1.16 and a status code.
//  - Configuration channel (cfg_valid_i / cfg_ready_o) writes the layer
//    thickness; write it only while no transaction is in flight.
//  - A two-entry queue sits between front and back, so the front keeps
//    taking transactions while the back works or the receiver stalls.
//  - Work per transaction in the back end: clear, append, no-op and a query
//    answered without the table go straight to the output; a query of entry
//    0 or the last entry reads it and runs one pass of the shared divider,
//    one inside the layer runs two, or three with interpolation. The shared
//    one-bit-per-cycle divider sets the query rate.
//  - A stalled output holds its result; the back end waits with the next
//    result until the output register is free, then the queue fills up and
//    in_stall_o rises.
//  - Reset empties the table and queue, clears the maximum and sets the
//    thickness to 1.0. Table contents are not cleared.
module depth_attenuation_interpolator import dai_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         command_i,
  input  logic [15:0]        entry_value_i,
  input  logic signed [31:0] y_coord_i,
  input  logic               interpolate_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [16:0]        attenuation_o,
  output logic [1:0]         status_o
);

  logic [31:0] thickness_q;
  logic        push, full, q_valid, q_pop;
  q_item_t     front_item, back_item;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thickness_q <= THICKNESS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thickness_q <= cfg_wdata_i;
    end
  end

  dai_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .entry_value_i (entry_value_i),
    .y_coord_i     (y_coord_i),
    .interpolate_i (interpolate_i),
    .thickness_i   (thickness_q),
    .full_i        (full),
    .push_o        (push),
    .item_o        (front_item)
  );

  dai_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (back_item)
  );

  dai_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  dai_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .thickness_i   (thickness_q),
    .q_valid_i     (q_valid),
    .q_item_i      (back_item),
    .q_pop_o       (q_pop),
    .div_req_o     (div_req),
    .div_rsp_i     (div_rsp),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .attenuation_o (attenuation_o),
    .status_o      (status_o)
  );

endmodule
